// ===== rtl/ffdra_pkg.sv =====
// Shared types, widths and codes of the first-fit descriptor range allocator.
// No dependencies; imported by every module of the block.
package ffdra_pkg;

    localparam int HEAP_DESCRIPTORS_DEF  = 65536;
    localparam int FREE_LIST_ENTRIES_DEF = 64;

    localparam int COUNT_W   = 17;
    localparam int ADDR_W    = 64;
    localparam int STRIDE_W  = 9;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 152;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUMPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  cpu;
        logic [ADDR_W-1:0]  gpu;
        logic [COUNT_W-1:0] count;
    } free_entry_t;

endpackage

// ===== rtl/ffdra_list_ram.sv =====
// Released-range list storage: one write port, one read port, registered read.
// Depends on ffdra_pkg for the entry type.
module ffdra_list_ram
    import ffdra_pkg::*;
#(
    parameter int DEPTH = FREE_LIST_ENTRIES_DEF,
    parameter int IDX_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  free_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output free_entry_t       rd_data
);

    free_entry_t mem [DEPTH];
    free_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ffdra_addr_calc.sv =====
// Bump address unit: offset times stride, registered, then added to both bases.
// Depends on ffdra_pkg for widths.
module ffdra_addr_calc
    import ffdra_pkg::*;
#(
    parameter int OFF_W = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [OFF_W-1:0]    offset,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [ADDR_W-1:0]   cpu_base,
    input  logic [ADDR_W-1:0]   gpu_base,
    output logic                done,
    output logic [ADDR_W-1:0]   cpu_addr,
    output logic [ADDR_W-1:0]   gpu_addr
);

    localparam int PROD_W = OFF_W + STRIDE_W;

    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W-1:0] cpu_addr_reg;
    logic [ADDR_W-1:0] gpu_addr_reg;
    logic [1:0]        stage_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
        end else begin
            stage_vld_reg <= {stage_vld_reg[0], start};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= PROD_W'(offset) * PROD_W'(stride);
        cpu_addr_reg <= cpu_base + ADDR_W'(prod_reg);
        gpu_addr_reg <= gpu_base + ADDR_W'(prod_reg);
    end

    assign done     = stage_vld_reg[1];
    assign cpu_addr = cpu_addr_reg;
    assign gpu_addr = gpu_addr_reg;

endmodule

// ===== rtl/first_fit_descriptor_range_allocator_core.sv =====
// First-fit descriptor range allocator: stream channels, sequencer and config.
// Depends on ffdra_pkg, ffdra_list_ram and ffdra_addr_calc.
//
// Usage:
//   s_ channel carries one request: s_tuser is the kind (allocate/release),
//   s_tdata holds count, CPU and GPU table addresses. m_ channel returns one
//   result per request: m_tdata holds CPU address, GPU address and granted
//   count, m_tuser the status. cfg_ writes base addresses and stride; write
//   only while no request is in flight.
//   One request is worked at a time; s_tready is high only while idle.
//   Release: the status is set in the result register when the request is taken.
//   Allocate: the released list is scanned one entry per cycle through the
//   list memory read port, a hit then moves each later entry down one slot
//   per cycle, and a miss goes on to the bump check and the multiply/add unit.
//   Reset empties the list and the heap top and loads the register defaults;
//   no clearing pass is needed. A stalled m_ side holds its result; the next
//   request can still be taken and worked, and waits only to hand over.
module first_fit_descriptor_range_allocator_core
    import ffdra_pkg::*;
#(
    parameter int HEAP_DESCRIPTORS  = HEAP_DESCRIPTORS_DEF,
    parameter int FREE_LIST_ENTRIES = FREE_LIST_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // count[16:0], table_cpu_address, table_gpu_address, pad
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // cpu_address, gpu_address, granted_count, pad
    output logic [STATUS_W-1:0]  m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W  = (FREE_LIST_ENTRIES > 1) ? $clog2(FREE_LIST_ENTRIES) : 1;
    localparam int USED_W = $clog2(FREE_LIST_ENTRIES + 1);
    localparam int OFF_W  = $clog2(HEAP_DESCRIPTORS + 1);
    localparam int SUM_W  = ((OFF_W > COUNT_W) ? OFF_W : COUNT_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_BUMP  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  req_count_reg;
    logic [USED_W-1:0]   used_reg;
    logic [USED_W-1:0]   idx_reg;
    logic [OFF_W-1:0]    offset_reg;
    logic [ADDR_W-1:0]   res_cpu_reg, res_gpu_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_tvalid_reg;
    logic [ADDR_W-1:0]   m_cpu_reg, m_gpu_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   cpu_base_reg, gpu_base_reg;
    logic [STRIDE_W-1:0] stride_reg;

    logic               s_accept, out_free, list_full, hit, fits;
    logic [COUNT_W-1:0] in_count;
    logic [ADDR_W-1:0]  in_cpu, in_gpu;
    logic [USED_W:0]    used_ext, idx_p1, idx_p2;
    logic [SUM_W-1:0]   bump_sum;

    logic              ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
    free_entry_t       ram_wr_data, ram_rd_data;

    logic              calc_start, calc_done;
    logic [ADDR_W-1:0] calc_cpu, calc_gpu;

    assign in_count = s_tdata[COUNT_W-1:0];
    assign in_cpu   = s_tdata[COUNT_W +: ADDR_W];
    assign in_gpu   = s_tdata[COUNT_W+ADDR_W +: ADDR_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign out_free  = !m_tvalid_reg | m_tready;
    assign cfg_ready = 1'b1;

    assign used_ext  = {1'b0, used_reg};
    assign idx_p1    = {1'b0, idx_reg} + (USED_W+1)'(1);
    assign idx_p2    = {1'b0, idx_reg} + (USED_W+1)'(2);
    assign list_full = (used_ext >= (USED_W+1)'(FREE_LIST_ENTRIES));
    // Shared compare: oldest-first fit test of the entry just read
    assign hit       = (ram_rd_data.count >= req_count_reg);
    assign bump_sum  = SUM_W'(offset_reg) + SUM_W'(req_count_reg);
    assign fits      = (bump_sum <= SUM_W'(HEAP_DESCRIPTORS));
    assign calc_start = (state_reg == S_BUMP) && fits;

    ffdra_list_ram #(
        .DEPTH (FREE_LIST_ENTRIES),
        .IDX_W (IDX_W)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ffdra_addr_calc #(
        .OFF_W (OFF_W)
    ) u_addr_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (calc_start),
        .offset   (offset_reg),
        .stride   (stride_reg),
        .cpu_base (cpu_base_reg),
        .gpu_base (gpu_base_reg),
        .done     (calc_done),
        .cpu_addr (calc_cpu),
        .gpu_addr (calc_gpu)
    );

    // List memory port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = used_reg[IDX_W-1:0];
        ram_wr_data = '{cpu: in_cpu, gpu: in_gpu, count: in_count};
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && s_tuser == KIND_RELEASE && !list_full) begin
                    ram_wr_en = 1'b1;
                end
                if (s_accept && s_tuser == KIND_ALLOC && used_reg != '0) begin
                    ram_rd_en = 1'b1;
                end
            end
            S_SCAN: begin
                ram_rd_en   = (idx_p1 < used_ext);
                ram_rd_addr = idx_p1[IDX_W-1:0];
            end
            S_SHIFT: begin
                // move entry idx+1 down into idx, fetch the one after
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[IDX_W-1:0];
                ram_wr_data = ram_rd_data;
                ram_rd_en   = (idx_p2 < used_ext);
                ram_rd_addr = idx_p2[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == KIND_RELEASE) begin
                        state_next = S_PUSH;
                    end else if (used_reg == '0) begin
                        state_next = S_BUMP;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = (idx_p1 < used_ext) ? S_SHIFT : S_PUSH;
                end else if (!(idx_p1 < used_ext)) begin
                    state_next = S_BUMP;
                end
            end
            S_SHIFT: begin
                if (!(idx_p2 < used_ext)) begin
                    state_next = S_PUSH;
                end
            end
            S_BUMP: begin
                state_next = fits ? S_MUL : S_PUSH;
            end
            S_MUL: begin
                if (calc_done) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            stride_reg   <= STRIDE_RESET;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CPU_BASE: cpu_base_reg <= cfg_data;
                    CFG_GPU_BASE: gpu_base_reg <= cfg_data;
                    CFG_STRIDE:   stride_reg   <= cfg_data[STRIDE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == S_IDLE && s_accept && s_tuser == KIND_RELEASE && !list_full) begin
                used_reg <= used_reg + USED_W'(1);
            end
            // drop the taken entry once compaction is over
            if ((state_reg == S_SCAN && hit && !(idx_p1 < used_ext)) ||
                (state_reg == S_SHIFT && !(idx_p2 < used_ext))) begin
                used_reg <= used_reg - USED_W'(1);
            end
            if (calc_start) begin
                offset_reg <= bump_sum[OFF_W-1:0];
            end

            if (state_reg == S_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_count_reg  <= in_count;
                    idx_reg        <= '0;
                    res_cpu_reg    <= '0;
                    res_gpu_reg    <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= list_full ? ST_FULL : ST_RELEASED;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    res_cpu_reg    <= ram_rd_data.cpu;
                    res_gpu_reg    <= ram_rd_data.gpu;
                    res_count_reg  <= req_count_reg;
                    res_status_reg <= ST_REUSED;
                end else begin
                    idx_reg <= idx_p1[USED_W-1:0];
                end
            end
            S_SHIFT: begin
                idx_reg <= idx_p1[USED_W-1:0];
            end
            S_BUMP: begin
                if (!fits) begin
                    res_cpu_reg    <= '0;
                    res_gpu_reg    <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= ST_NO_SPACE;
                end
            end
            S_MUL: begin
                if (calc_done) begin
                    res_cpu_reg    <= calc_cpu;
                    res_gpu_reg    <= calc_gpu;
                    res_count_reg  <= req_count_reg;
                    res_status_reg <= ST_BUMPED;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    m_cpu_reg    <= res_cpu_reg;
                    m_gpu_reg    <= res_gpu_reg;
                    m_count_reg  <= res_count_reg;
                    m_status_reg <= res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-2*ADDR_W-COUNT_W){1'b0}}, m_count_reg, m_gpu_reg, m_cpu_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== dv/ffdra_grant_checker.sv =====
`timescale 1ns / 100ps
// Checker for the first-fit descriptor range allocator: watches the request, result
// and register-write channels, predicts every grant and compares it field by field.
// Depends on ffdra_pkg.
module ffdra_grant_checker
    import ffdra_pkg::*;
#(
    parameter int HEAP_DESCRIPTORS  = HEAP_DESCRIPTORS_DEF,
    parameter int FREE_LIST_ENTRIES = FREE_LIST_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_grants,
    output logic [COUNT_W-1:0]   heap_top
);

    typedef struct {
        logic [ADDR_W-1:0]   cpu;
        logic [ADDR_W-1:0]   gpu;
        logic [COUNT_W-1:0]  granted;
        logic [STATUS_W-1:0] status;
    } grant_t;

    grant_t              expected_grants[$];
    free_entry_t         released_ranges[$];
    logic [COUNT_W-1:0]  heap_offset;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic [STRIDE_W-1:0] stride;
    int                  mismatch_total = 0;

    assign fail_count = mismatch_total;

    function automatic grant_t predict_grant(input logic kind, input logic [COUNT_W-1:0] cnt,
                                             input logic [ADDR_W-1:0] tcpu,
                                             input logic [ADDR_W-1:0] tgpu);
        grant_t            g;
        int                hit;
        logic [ADDR_W-1:0] offs;
        free_entry_t       rng;
        g   = '{cpu: '0, gpu: '0, granted: '0, status: ST_NO_SPACE};
        hit = -1;
        if (kind == KIND_RELEASE) begin
            if (released_ranges.size() < FREE_LIST_ENTRIES) begin
                rng             = '{cpu: tcpu, gpu: tgpu, count: cnt};
                released_ranges = {released_ranges, rng};
                g.status        = ST_RELEASED;
            end else begin
                g.status = ST_FULL;
            end
            return g;
        end
        // first fit, oldest entry first
        foreach (released_ranges[i]) begin
            if (hit < 0 && released_ranges[i].count >= cnt) hit = i;
        end
        if (hit >= 0) begin
            g.cpu     = released_ranges[hit].cpu;
            g.gpu     = released_ranges[hit].gpu;
            g.granted = cnt;
            g.status  = ST_REUSED;
            released_ranges.delete(hit);
        end else if (int'(heap_offset) + int'(cnt) <= HEAP_DESCRIPTORS) begin
            offs        = ADDR_W'(heap_offset) * ADDR_W'(stride);
            g.cpu       = cpu_base + offs;
            g.gpu       = gpu_base + offs;
            g.granted   = cnt;
            g.status    = ST_BUMPED;
            heap_offset = heap_offset + cnt;
        end
        return g;
    endfunction

    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        grant_t want;
        grant_t next_grant;
        if (!aresetn) begin
            expected_grants.delete();
            released_ranges.delete();
            heap_offset = '0;
            cpu_base    = '0;
            gpu_base    = '0;
            stride      = STRIDE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CPU_BASE: cpu_base = cfg_data;
                    CFG_GPU_BASE: gpu_base = cfg_data;
                    CFG_STRIDE:   stride   = cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            // a result always trails its request, so retire before taking a new one
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h %h",
                             $time, m_tdata, m_tuser);
                    mismatch_total++;
                end else begin
                    want = expected_grants.pop_front();
                    check_field("cpu_address", want.cpu, m_tdata[63:0]);
                    check_field("gpu_address", want.gpu, m_tdata[127:64]);
                    check_field("granted_count", ADDR_W'(want.granted), ADDR_W'(m_tdata[144:128]));
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                next_grant      = predict_grant(s_tuser, s_tdata[16:0],
                                                s_tdata[80:17], s_tdata[144:81]);
                expected_grants = {expected_grants, next_grant};
            end
        end
        pending_grants <= expected_grants.size();
        heap_top       <= heap_offset;
    end

endmodule

// ===== dv/first_fit_descriptor_range_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the first-fit descriptor range allocator: clock, reset, request
// and register-write stimulus, result-side stalls and the verdict.
// Depends on ffdra_pkg, ffdra_grant_checker and the allocator RTL.
module first_fit_descriptor_range_allocator_core_tb;
    import ffdra_pkg::*;

    localparam int RUN_LIMIT     = 6_000_000;
    localparam int SETTLE_CYCLES = 2 * FREE_LIST_ENTRIES_DEF + 32;
    localparam int PHASE_ITEMS   = 342;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0]    ALL_ONES  = '1;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;  // count, table_cpu_address, table_gpu_address, pad
    logic                 s_tuser   = 1'b0; // kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;         // cpu_address, gpu_address, granted_count, pad
    logic [STATUS_W-1:0]  m_tuser;         // status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    int                 fail_count;
    int                 pending_grants;
    logic [COUNT_W-1:0] heap_top;
    bit                 steady_send = 1'b0;

    first_fit_descriptor_range_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ffdra_grant_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_grants (pending_grants),
        .heap_top       (heap_top)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // keep most bumps small so the heap lasts through the random phases
    function automatic logic [COUNT_W-1:0] alloc_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return COUNT_W'($urandom_range(0, 40));
        if (r < 90) return COUNT_W'($urandom_range(41, 300));
        if (r < 97) return COUNT_W'($urandom_range(65536, 131071));
        return '0;
    endfunction

    function automatic logic [COUNT_W-1:0] release_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return COUNT_W'($urandom_range(0, 63));
        if (r < 75) return COUNT_W'($urandom_range(64, 2000));
        return COUNT_W'($urandom_range(0, 131071));
    endfunction

    task automatic issue_request(input logic kind, input logic [COUNT_W-1:0] cnt,
                                 input logic [ADDR_W-1:0] tcpu, input logic [ADDR_W-1:0] tgpu);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, tgpu, tcpu, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every grant is back and the block has gone quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_grants != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int release_pct);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) steady_send = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < release_pct)
                issue_request(KIND_RELEASE, release_size(), rand64(), rand64());
            else
                issue_request(KIND_ALLOC, alloc_size(), rand64(), rand64());
        end
        drain_results();
    endtask

    task automatic set_registers(input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
                                 input logic [STRIDE_W-1:0] str);
        write_register(CFG_CPU_BASE, cpu);
        write_register(CFG_GPU_BASE, gpu);
        // upper data bits are don't-care for the stride
        write_register(CFG_STRIDE, (rand64() << STRIDE_W) | ADDR_W'(str));
    endtask

    // request stimulus and verdict
    initial begin : stimulus
        int room;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default registers, empty list
        issue_request(KIND_ALLOC,   17'd0,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd1,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd65536,  rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd131071, rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd0,      '0, '0);
        issue_request(KIND_RELEASE, 17'd131071, ALL_ONES, ALL_ONES);
        issue_request(KIND_RELEASE, 17'd5,      rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd100,    rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd0,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd50,     rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd101,    rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd100,    rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd7,      rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd8,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd6,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd5,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd9,      rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd65536,  ALL_ONES, rand64());
        issue_request(KIND_ALLOC,   17'd65536,  rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd8,      rand64(), rand64());
        issue_request(KIND_ALLOC,   17'd0,      rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd1,      rand64(), ALL_ONES);
        issue_request(KIND_ALLOC,   17'd131071, rand64(), rand64());
        drain_results();

        set_registers(ALL_ONES, '0, 9'd1);
        run_phase(35);
        set_registers(rand64(), rand64(), 9'd256);
        write_register(CFG_SPARE, rand64());
        run_phase(50);
        // heavy release traffic fills the list
        set_registers('0, ALL_ONES, 9'd0);
        run_phase(85);
        set_registers(rand64(), rand64(), 9'd511);
        run_phase(20);
        set_registers(rand64(), rand64(), 9'($urandom_range(1, 256)));
        run_phase(50);

        // empty the list, then walk the heap up to its exact end
        for (int i = 0; i <= FREE_LIST_ENTRIES_DEF; i++)
            issue_request(KIND_ALLOC, 17'd0, rand64(), rand64());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        room = HEAP_DESCRIPTORS_DEF - int'(heap_top);
        issue_request(KIND_ALLOC, COUNT_W'(room + 1), rand64(), rand64());
        issue_request(KIND_ALLOC, COUNT_W'(room), rand64(), rand64());
        issue_request(KIND_ALLOC, 17'd0, rand64(), rand64());
        issue_request(KIND_ALLOC, 17'd1, rand64(), rand64());
        issue_request(KIND_RELEASE, 17'd3, rand64(), rand64());
        issue_request(KIND_ALLOC, 17'd2, rand64(), rand64());
        drain_results();

        if (fail_count == 0 && pending_grants == 0)
            $display("first_fit_descriptor_range_allocator_core verification clean");
        else
            $display("first_fit_descriptor_range_allocator_core verification failed");
        $finish;
    end

    // result side: random stalls, plus long holds that back the block up
    initial begin : result_side
        int  hold;
        int  cycles;
        bit  steady_take;
        hold        = 0;
        cycles      = 0;
        steady_take = 1'b0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles % 256 == 0) steady_take = ($urandom_range(0, 2) == 0);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (cycles == 4000 || $urandom_range(0, 4999) == 0) begin
                hold = $urandom_range(300, 600);
                m_tready <= 1'b0;
            end else if (!steady_take && $urandom_range(0, 3) == 0) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("first_fit_descriptor_range_allocator_core verification failed");
        $finish;
    end

endmodule
